// ===== rtl/plt_pkg.sv =====
`default_nettype none

package plt_pkg;

	// Table size and field widths.
	localparam int SYMBOLS_DEF = 1024;
	localparam int VAL_W       = 64;
	localparam int EXPO_W      = 63;

	// Action codes; unused codes behave as a query.
	localparam logic [2:0] ACT_FILL   = 3'd0;
	localparam logic [2:0] ACT_ADD    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_QUERY  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOR  = 2'd1;
	localparam logic [1:0] ST_NEG  = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	// One ledger entry as it is stored in the table.
	typedef struct packed {
		logic [VAL_W-1:0] net;
		logic [VAL_W-1:0] notional;
		logic [VAL_W-1:0] bought;
		logic [VAL_W-1:0] sold;
		logic [VAL_W-1:0] bid;
		logic [VAL_W-1:0] ask;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/plt_mem.sv =====
`default_nettype none

module plt_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire plt_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output plt_pkg::entry_t      rdata
);
	import plt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/plt_risk.sv =====
`default_nettype none

module plt_risk (
	input  wire logic                        clk,
	input  wire plt_pkg::entry_t             ent,
	input  wire logic signed [31:0]          mark,
	output logic [plt_pkg::EXPO_W-1:0]       expo,
	output logic [plt_pkg::VAL_W-1:0]        profit
);
	import plt_pkg::*;

	logic [VAL_W-1:0]  sum_a_s1, sum_b_s1, notional_s1, pp0_s1;
	logic [31:0]       net_hi_s1, mark_s1;
	logic signed [64:0] pp0_full;

	logic [VAL_W-1:0]  mag_a_s2, mag_b_s2, notional_s2, pp0_s2;
	logic [31:0]       pp1_s2;
	logic [63:0]       pp1_full;

	logic [VAL_W-1:0]  max_mag;
	logic [EXPO_W-1:0] expo_s3;
	logic [VAL_W-1:0]  profit_s3;

	// Low half of net times the sign-extended mark.
	assign pp0_full = $signed({1'b0, ent.net[31:0]}) * mark;

	// Stage 1: position sums with working lots, first partial product.
	always_ff @(posedge clk) begin
		sum_a_s1    <= ent.net + ent.bid;
		sum_b_s1    <= ent.net - ent.ask;
		pp0_s1      <= pp0_full[VAL_W-1:0];
		net_hi_s1   <= ent.net[63:32];
		mark_s1     <= mark;
		notional_s1 <= ent.notional;
	end

	// Only the low 32 bits of the high partial product reach the result.
	assign pp1_full = net_hi_s1 * mark_s1;

	// Stage 2: magnitudes, second partial product.
	always_ff @(posedge clk) begin
		mag_a_s2    <= sum_a_s1[63] ? (64'd0 - sum_a_s1) : sum_a_s1;
		mag_b_s2    <= sum_b_s1[63] ? (64'd0 - sum_b_s1) : sum_b_s1;
		pp1_s2      <= pp1_full[31:0];
		pp0_s2      <= pp0_s1;
		notional_s2 <= notional_s1;
	end

	assign max_mag = (mag_a_s2 > mag_b_s2) ? mag_a_s2 : mag_b_s2;

	// Stage 3: saturated exposure and profit.
	always_ff @(posedge clk) begin
		expo_s3   <= max_mag[63] ? {EXPO_W{1'b1}} : max_mag[EXPO_W-1:0];
		profit_s3 <= pp0_s2 + {pp1_s2, 32'd0} - notional_s2;
	end

	assign expo   = expo_s3;
	assign profit = profit_s3;

endmodule

`default_nettype wire

// ===== rtl/position_ledger_table.sv =====
// Position ledger table: one ledger entry per symbol, kept in a wide
// single-port-write, registered-read memory.
// Input channel (in_valid/in_ready) takes one item: action, symbol, side,
// fill_price, lot_count and mark_price. Output channel (out_valid/out_ready)
// returns exactly one result item per input item: the status, the entry
// after the update, the gross exposure and the profit at the mark price.
// Items are handled one at a time by a sequencer: read the entry, form the
// fill notional, update and write back, then three stages of exposure and
// profit arithmetic. The next item is taken only once the current result
// has entered the output register.
// The output register holds a finished result while the receiver stalls;
// the block still accepts the next item, and that item waits in its final
// step until the register frees up.
// After reset the block sweeps the table to zero, one entry per cycle;
// in_ready stays low until the sweep ends.
`default_nettype none

module position_ledger_table #(
	parameter int SYMBOLS = plt_pkg::SYMBOLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  action,
	input  wire logic [15:0]                 symbol,
	input  wire logic                        side,
	input  wire logic signed [31:0]          fill_price,
	input  wire logic [31:0]                 lot_count,
	input  wire logic signed [31:0]          mark_price,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic signed [plt_pkg::VAL_W-1:0] pos_net,
	output logic signed [plt_pkg::VAL_W-1:0] pos_notional,
	output logic signed [plt_pkg::VAL_W-1:0] buy_total,
	output logic signed [plt_pkg::VAL_W-1:0] sell_total,
	output logic signed [plt_pkg::VAL_W-1:0] working_bid,
	output logic signed [plt_pkg::VAL_W-1:0] working_ask,
	output logic [plt_pkg::EXPO_W-1:0]       gross_exposure,
	output logic signed [plt_pkg::VAL_W-1:0] profit
);
	import plt_pkg::*;

	localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_R1    = 3'd4;
	localparam logic [2:0] S_R2    = 3'd5;
	localparam logic [2:0] S_R3    = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic               accept;

	logic [2:0]         action_q;
	logic [AW-1:0]      addr_q;
	logic               oor_q;
	logic               side_q;
	logic signed [31:0] price_q;
	logic [31:0]        lots_q;
	logic signed [31:0] mark_q;

	logic signed [65:0] prod_full;
	logic [VAL_W-1:0]   prod_q;

	entry_t             rdata;
	entry_t             upd_ent;
	logic [1:0]         upd_status;
	logic [VAL_W-1:0]   lots64;
	entry_t             ent_q;
	logic [1:0]         st_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;

	logic [EXPO_W-1:0]  risk_expo;
	logic [VAL_W-1:0]   risk_profit;

	logic               out_valid_q;
	entry_t             res_ent_q;
	logic [1:0]         res_status_q;
	logic [EXPO_W-1:0]  res_expo_q;
	logic [VAL_W-1:0]   res_profit_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Sequencer: clearing sweep after reset, then one item at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(SYMBOLS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_UPD;
				S_UPD: state_q <= S_R1;
				S_R1:  state_q <= S_R2;
				S_R2:  state_q <= S_R3;
				S_R3:  state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Capture the item's fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			addr_q   <= symbol[AW-1:0];
			oor_q    <= ({1'b0, symbol} >= 17'(SYMBOLS));
			side_q   <= side;
			price_q  <= fill_price;
			lots_q   <= lot_count;
			mark_q   <= mark_price;
		end
	end

	// Fill notional, formed while the entry is read.
	assign prod_full = $signed({price_q[31], price_q}) * $signed({1'b0, lots_q});

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			prod_q <= prod_full[VAL_W-1:0];
		end
	end

	// Read-modify of the entry.
	assign lots64 = {32'd0, lots_q};

	always_comb begin
		upd_ent    = rdata;
		upd_status = ST_OK;
		case (action_q)
			ACT_FILL: begin
				if (lots_q == 32'd0) begin
					upd_status = ST_ZERO;
				end else if (side_q) begin
					upd_ent.net      = rdata.net - lots64;
					upd_ent.notional = rdata.notional - prod_q;
					upd_ent.sold     = rdata.sold + lots64;
				end else begin
					upd_ent.net      = rdata.net + lots64;
					upd_ent.notional = rdata.notional + prod_q;
					upd_ent.bought   = rdata.bought + lots64;
				end
			end
			ACT_ADD: begin
				if (side_q) begin
					upd_ent.ask = rdata.ask + lots64;
				end else begin
					upd_ent.bid = rdata.bid + lots64;
				end
			end
			ACT_REMOVE: begin
				if (side_q) begin
					upd_ent.ask = rdata.ask - lots64;
					if (upd_ent.ask[63]) begin
						upd_status = ST_NEG;
					end
				end else begin
					upd_ent.bid = rdata.bid - lots64;
					if (upd_ent.bid[63]) begin
						upd_status = ST_NEG;
					end
				end
			end
			ACT_CLEAR: upd_ent = '0;
			default:   upd_ent = rdata;
		endcase
		if (oor_q) begin
			upd_ent    = '0;
			upd_status = ST_OOR;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ent_q <= upd_ent;
			st_q  <= upd_status;
		end
	end

	// Memory write: zero sweep or write-back of an in-range entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = upd_ent;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_UPD) begin
			mem_we = !oor_q;
		end
	end

	plt_mem #(
		.DEPTH(SYMBOLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(symbol[AW-1:0]),
		.rdata(rdata)
	);

	plt_risk u_risk (
		.clk   (clk),
		.ent   (ent_q),
		.mark  (mark_q),
		.expo  (risk_expo),
		.profit(risk_profit)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			res_ent_q    <= ent_q;
			res_status_q <= st_q;
			res_expo_q   <= risk_expo;
			res_profit_q <= risk_profit;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign pos_net        = res_ent_q.net;
	assign pos_notional   = res_ent_q.notional;
	assign buy_total      = res_ent_q.bought;
	assign sell_total     = res_ent_q.sold;
	assign working_bid    = res_ent_q.bid;
	assign working_ask    = res_ent_q.ask;
	assign gross_exposure = res_expo_q;
	assign profit         = res_profit_q;

	// An out-of-range item never writes the table.
	a_no_oor_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && oor_q) |-> !mem_we)
		else $error("table written for an out-of-range symbol");

	// An out-of-range result carries a zero entry and zero profit.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OOR) |->
		(pos_net == '0 && working_bid == '0 && working_ask == '0 && profit == '0))
		else $error("out-of-range result is not zero");

	// A negative-working status always shows a negative working slot.
	a_neg_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NEG) |-> (working_bid[63] || working_ask[63]))
		else $error("negative status without a negative working slot");

	// A new result appears only from the final step of the sequencer.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result appeared outside the final step");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
	import plt_pkg::*;

	localparam int ITEM_TARGET   = 1600;
	localparam int HOT_SYMBOLS   = 12;
	localparam int IDLE_LIMIT    = 5000;
	localparam int DRAIN_CYCLES  = 30;
	localparam int HOLD_AT       = 400;
	localparam int HOLD_CYCLES   = 500;
	localparam int PRINT_CAP     = 50;

	// One input item and one result item, at the widths of the ports.
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] symbol;
		logic        side;
		logic [31:0] fill_price;
		logic [31:0] lot_count;
		logic [31:0] mark_price;
	} ledger_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] net;
		logic [63:0] notional;
		logic [63:0] bought;
		logic [63:0] sold;
		logic [63:0] bid;
		logic [63:0] ask;
		logic [62:0] expo;
		logic [63:0] profit;
	} ledger_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [15:0] symbol = '0;
	logic        side = 1'b0;
	logic signed [31:0] fill_price = '0;
	logic [31:0] lot_count = '0;
	logic signed [31:0] mark_price = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic signed [63:0] pos_net, pos_notional, buy_total, sell_total;
	logic signed [63:0] working_bid, working_ask, profit;
	logic [62:0] gross_exposure;

	// Testbench copy of the ledger, the items still to send and the rows awaited.
	entry_t       ledger_book [SYMBOLS_DEF];
	ledger_item_t order_feed [$];
	ledger_row_t  awaited_rows [$];
	logic [15:0]  hot_symbols [HOT_SYMBOLS];

	int errors = 0;
	int sent_count = 0;
	int checked_count = 0;
	int status_tally [4];

	position_ledger_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .symbol(symbol), .side(side),
		.fill_price(fill_price), .lot_count(lot_count), .mark_price(mark_price),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .pos_net(pos_net), .pos_notional(pos_notional),
		.buy_total(buy_total), .sell_total(sell_total),
		.working_bid(working_bid), .working_ask(working_ask),
		.gross_exposure(gross_exposure), .profit(profit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one item to the ledger copy and returns the row the block should report.
	function automatic ledger_row_t post_to_ledger(ledger_item_t it);
		ledger_row_t row;
		entry_t      e;
		logic [63:0] price64, lots64, mark64, sum_bid, sum_ask, mag_bid, mag_ask, worst;
		row = '0;
		if (it.symbol >= SYMBOLS_DEF) begin
			row.status = ST_OOR;
			return row;
		end
		e = ledger_book[it.symbol];
		row.status = ST_OK;
		price64 = {{32{it.fill_price[31]}}, it.fill_price};
		mark64 = {{32{it.mark_price[31]}}, it.mark_price};
		lots64 = {32'd0, it.lot_count};
		case (it.action)
			ACT_FILL: begin
				if (lots64 == 0) begin
					row.status = ST_ZERO;
				end else if (it.side) begin
					e.net = e.net - lots64;
					e.notional = e.notional - price64 * lots64;
					e.sold = e.sold + lots64;
				end else begin
					e.net = e.net + lots64;
					e.notional = e.notional + price64 * lots64;
					e.bought = e.bought + lots64;
				end
			end
			ACT_ADD: begin
				if (it.side) e.ask = e.ask + lots64;
				else e.bid = e.bid + lots64;
			end
			ACT_REMOVE: begin
				if (it.side) begin
					e.ask = e.ask - lots64;
					if (e.ask[63]) row.status = ST_NEG;
				end else begin
					e.bid = e.bid - lots64;
					if (e.bid[63]) row.status = ST_NEG;
				end
			end
			ACT_CLEAR: e = '0;
			default: ;
		endcase
		ledger_book[it.symbol] = e;

		// Exposure is the worse magnitude of the two one-sided outcomes, clipped to 63 bits.
		sum_bid = e.net + e.bid;
		sum_ask = e.net - e.ask;
		mag_bid = sum_bid[63] ? 64'd0 - sum_bid : sum_bid;
		mag_ask = sum_ask[63] ? 64'd0 - sum_ask : sum_ask;
		worst = (mag_bid > mag_ask) ? mag_bid : mag_ask;
		row.expo = worst[63] ? {63{1'b1}} : worst[62:0];

		row.net = e.net;
		row.notional = e.notional;
		row.bought = e.bought;
		row.sold = e.sold;
		row.bid = e.bid;
		row.ask = e.ask;
		row.profit = e.net * mark64 - e.notional;
		return row;
	endfunction

	task automatic queue_order(input logic [2:0] act, input logic [15:0] sym,
			input logic sd, input logic [31:0] price, input logic [31:0] lots,
			input logic [31:0] mark);
		ledger_item_t it;
		it.action = act;
		it.symbol = sym;
		it.side = sd;
		it.fill_price = price;
		it.lot_count = lots;
		it.mark_price = mark;
		order_feed.push_back(it);
	endtask

	// Mostly modest lot sizes so positions build up, with full-width values mixed in.
	function automatic logic [31:0] pick_lots();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 500);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_price();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 32'($urandom_range(0, 4000)) - 32'd2000;
		return $urandom;
	endfunction

	// A working order on a hot symbol: rest lots, fill part of them, pull the rest.
	task automatic queue_order_lifecycle();
		logic [15:0] sym;
		logic        sd;
		logic [31:0] lots, remaining, part, extra, mark;
		int          parts;
		sym = hot_symbols[$urandom_range(0, HOT_SYMBOLS - 1)];
		sd = 1'($urandom_range(0, 1));
		lots = pick_lots();
		mark = pick_price();
		queue_order(ACT_ADD, sym, sd, pick_price(), lots, mark);
		remaining = lots;
		parts = $urandom_range(0, 3);
		for (int i = 0; i < parts; i++) begin
			part = (remaining == 0) ? 32'd0 : 32'($urandom_range(0, remaining));
			queue_order(ACT_FILL, sym, sd, pick_price(), part, mark);
			remaining = remaining - part;
		end
		extra = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(1, 50)) : 32'd0;
		queue_order(ACT_REMOVE, sym, sd, pick_price(), remaining + extra, pick_price());
		if ($urandom_range(0, 3) == 0)
			queue_order(ACT_QUERY, sym, 1'($urandom_range(0, 1)), $urandom, $urandom,
				pick_price());
		if ($urandom_range(0, 24) == 0)
			queue_order(ACT_CLEAR, sym, 1'($urandom_range(0, 1)), $urandom, $urandom,
				pick_price());
	endtask

	function automatic int sender_gap();
		int unsigned r;
		if ((sent_count / 250) % 2 == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic int receiver_stall();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < PRINT_CAP)
			$display("MISMATCH result %0d %s: got %h, want %h", checked_count, what, got, want);
		errors++;
	endtask

	// Driver: offers queued items, predicts each one as it is accepted.
	ledger_item_t offered;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_rows.push_back(post_to_ledger(offered));
				sent_count++;
				gap_left = sender_gap();
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || order_feed.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					offered = order_feed.pop_front();
					action <= offered.action;
					symbol <= offered.symbol;
					side <= offered.side;
					fill_price <= offered.fill_price;
					lot_count <= offered.lot_count;
					mark_price <= offered.mark_price;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest awaited row and
	// drives out_ready, including one long hold that backs the block up.
	ledger_row_t want;
	int  hold_left = 0;
	int  rx_cycle = 0;
	bit  pressure_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				if (awaited_rows.size() == 0) begin
					flag_mismatch("unexpected result", {62'd0, status}, 64'd0);
				end else begin
					want = awaited_rows.pop_front();
					status_tally[want.status]++;
					if (status !== want.status)
						flag_mismatch("status", {62'd0, status}, {62'd0, want.status});
					if (pos_net !== want.net) flag_mismatch("pos_net", pos_net, want.net);
					if (pos_notional !== want.notional)
						flag_mismatch("pos_notional", pos_notional, want.notional);
					if (buy_total !== want.bought)
						flag_mismatch("buy_total", buy_total, want.bought);
					if (sell_total !== want.sold)
						flag_mismatch("sell_total", sell_total, want.sold);
					if (working_bid !== want.bid) flag_mismatch("working_bid", working_bid, want.bid);
					if (working_ask !== want.ask) flag_mismatch("working_ask", working_ask, want.ask);
					if (gross_exposure !== want.expo)
						flag_mismatch("gross_exposure", {1'b0, gross_exposure}, {1'b0, want.expo});
					if (profit !== want.profit) flag_mismatch("profit", profit, want.profit);
				end
				checked_count++;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!pressure_done && checked_count >= HOLD_AT) begin
				pressure_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if ((rx_cycle / 300) % 2 == 0) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				hold_left = receiver_stall() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if neither channel moves an item for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < SYMBOLS_DEF; i++) ledger_book[i] = '0;
		for (int i = 0; i < 4; i++) status_tally[i] = 0;
		hot_symbols[0] = 16'd0;
		hot_symbols[1] = 16'(SYMBOLS_DEF - 1);
		for (int i = 2; i < HOT_SYMBOLS; i++)
			hot_symbols[i] = 16'($urandom_range(0, SYMBOLS_DEF - 1));

		// Directed: field extremes, each action, and the flagged cases.
		queue_order(ACT_QUERY, 16'd0, 1'b0, 32'h0, 32'h0, 32'h0);
		queue_order(ACT_FILL, 16'd0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
		queue_order(ACT_FILL, 16'd0, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_order(ACT_FILL, 16'd0, 1'b1, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
		queue_order(ACT_FILL, 16'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		queue_order(ACT_ADD, 16'd1, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h10);
		queue_order(ACT_ADD, 16'd1, 1'b1, 32'h0, 32'd5, 32'h10);
		queue_order(ACT_REMOVE, 16'd1, 1'b0, 32'h0, 32'd10, 32'h10);
		queue_order(ACT_REMOVE, 16'd1, 1'b1, 32'h0, 32'd100, 32'h10);
		queue_order(ACT_REMOVE, 16'd2, 1'b0, 32'h0, 32'd1, 32'h0);
		queue_order(ACT_FILL, 16'd1, 1'b0, 32'd250, 32'd40, 32'd260);
		queue_order(ACT_CLEAR, 16'd1, 1'b0, 32'h0, 32'h0, 32'h0);
		queue_order(ACT_QUERY, 16'd1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
		queue_order(ACT_FILL, 16'(SYMBOLS_DEF), 1'b0, 32'd100, 32'd7, 32'd100);
		queue_order(3'd7, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_order(ACT_FILL, 16'(SYMBOLS_DEF - 1), 1'b0, 32'hFFFF_FFFF, 32'd3, 32'd9);
		queue_order(3'd5, 16'(SYMBOLS_DEF - 1), 1'b0, 32'h0, 32'd77, 32'd1);
		queue_order(3'd6, 16'(SYMBOLS_DEF - 1), 1'b1, 32'h0, 32'd77, 32'h8000_0000);
		queue_order(3'd7, 16'(SYMBOLS_DEF - 1), 1'b0, 32'h0, 32'd77, 32'h7FFF_FFFF);
		queue_order(ACT_FILL, 16'(SYMBOLS_DEF - 1), 1'b1, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		queue_order(ACT_ADD, 16'(SYMBOLS_DEF - 1), 1'b1, 32'h0, 32'hFFFF_FFFF, 32'd0);
		queue_order(ACT_REMOVE, 16'(SYMBOLS_DEF - 1), 1'b1, 32'h0, 32'hFFFF_FFFF, 32'd0);

		// Random: mostly order lifecycles on a few hot symbols, some raw noise.
		while (order_feed.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 85)
				queue_order_lifecycle();
			else
				queue_order(3'($urandom_range(0, 7)),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)), $urandom, pick_lots(), $urandom);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (order_feed.size() != 0 || in_valid || awaited_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_rows.size() != 0) begin
			$display("%0d awaited results never arrived", awaited_rows.size());
			errors++;
		end
		$display("Sent %0d items, checked %0d results with one long output hold.",
			sent_count, checked_count);
		$display("Status counts: ok %0d, out of range %0d, working negative %0d, zero lot %0d.",
			status_tally[ST_OK], status_tally[ST_OOR], status_tally[ST_NEG],
			status_tally[ST_ZERO]);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
